[hdl/assert_macros.svh]
// Assertion macros for the checker of the fixed-point ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define QFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qfa assertion failed");

// Check a consequent in the cycle after its antecedent.
`define QFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qfa assertion failed");

`endif

[hdl/qfa_pkg.sv]
// Shared constants, opcodes and arithmetic helpers of the Q16.16 ALU.
`default_nettype none
package qfa_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int OP_W   = 4;

    localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd3;
    localparam logic [OP_W-1:0] OP_CMP   = 4'd4;
    localparam logic [OP_W-1:0] OP_FLOOR = 4'd5;
    localparam logic [OP_W-1:0] OP_FRAC  = 4'd6;
    localparam logic [OP_W-1:0] OP_SIN   = 4'd7;
    localparam logic [OP_W-1:0] OP_COS   = 4'd8;

    localparam logic [DATA_W-1:0] Q_ONE      = 32'h0001_0000;
    localparam logic [DATA_W-1:0] FRAC_MASK  = 32'h0000_FFFF;
    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_W - 1);

    // Divider: quotient width, bits resolved per stage, stage count
    localparam int DIV_QW     = DATA_W + FRAC_W;
    localparam int DIV_BPS    = 2;
    localparam int DIV_STAGES = DIV_QW / DIV_BPS;

    // Whole pipe: entry register, divider stages, sign fix-up register
    localparam int PIPE_DEPTH = DIV_STAGES + 2;

    // Polynomial unit: entry, power chain, abs, scale, sign, sum, select
    localparam int POLY_CHAIN = 7;
    localparam int POLY_TERMS = 4;
    localparam int POLY_DEPTH = 1 + POLY_CHAIN + 5;
    localparam int POLY_PAD   = PIPE_DEPTH - POLY_DEPTH;

    // Reciprocals for truncating division by the series denominators;
    // shift is 32 plus ceil(log2(divisor)), exact for magnitudes to 2^32.
    localparam logic [63:0] TM_SIN0 = ((64'd1 << 35) + 64'd6 - 64'd1) / 64'd6;
    localparam logic [63:0] TM_SIN1 = ((64'd1 << 39) + 64'd120 - 64'd1) / 64'd120;
    localparam logic [63:0] TM_SIN2 = ((64'd1 << 45) + 64'd5040 - 64'd1) / 64'd5040;
    localparam logic [63:0] TM_COS0 = ((64'd1 << 33) + 64'd2 - 64'd1) / 64'd2;
    localparam logic [63:0] TM_COS1 = ((64'd1 << 37) + 64'd24 - 64'd1) / 64'd24;
    localparam logic [63:0] TM_COS2 = ((64'd1 << 42) + 64'd720 - 64'd1) / 64'd720;
    localparam logic [63:0] TM_COS3 = ((64'd1 << 48) + 64'd40320 - 64'd1) / 64'd40320;

    // Rounded Q16.16 multiply, wrapped to 32 bits
    function automatic logic [DATA_W-1:0] qmul(input logic [DATA_W-1:0] x,
                                               input logic [DATA_W-1:0] y);
        logic signed [63:0] prod;
        logic signed [63:0] rnd;
        prod = $signed(x) * $signed(y);
        rnd  = prod + ROUND_HALF;
        return rnd[DATA_W+FRAC_W-1:FRAC_W];
    endfunction

    // Reciprocal for one series term
    function automatic logic [DATA_W:0] term_magic(input logic is_cos,
                                                   input logic [1:0] slot);
        logic [DATA_W:0] m;
        case ({is_cos, slot})
            3'b000:  m = TM_SIN0[DATA_W:0];
            3'b001:  m = TM_SIN1[DATA_W:0];
            3'b010:  m = TM_SIN2[DATA_W:0];
            3'b100:  m = TM_COS0[DATA_W:0];
            3'b101:  m = TM_COS1[DATA_W:0];
            3'b110:  m = TM_COS2[DATA_W:0];
            3'b111:  m = TM_COS3[DATA_W:0];
            default: m = '0;
        endcase
        return m;
    endfunction

    // Right shift that goes with the reciprocal
    function automatic logic [5:0] term_shift(input logic is_cos,
                                              input logic [1:0] slot);
        logic [5:0] s;
        case ({is_cos, slot})
            3'b000:  s = 6'd35;
            3'b001:  s = 6'd39;
            3'b010:  s = 6'd45;
            3'b100:  s = 6'd33;
            3'b101:  s = 6'd37;
            3'b110:  s = 6'd42;
            3'b111:  s = 6'd48;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[hdl/qfa_req_if.sv]
// Request channel: opcode and two Q16.16 operands with valid/ready.
`default_nettype none
interface qfa_req_if import qfa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          req_type;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;

    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

[hdl/qfa_rsp_if.sv]
// Response channel: Q16.16 result and status flags with valid/ready.
`default_nettype none
interface qfa_rsp_if import qfa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic                     a_less_b;
    logic                     a_equal_b;
    logic                     divide_by_zero;

    modport source (output valid, result_value, a_less_b, a_equal_b, divide_by_zero,
                    input ready);
    modport sink (input valid, result_value, a_less_b, a_equal_b, divide_by_zero,
                  output ready);
endinterface
`default_nettype wire

[hdl/qfa_div.sv]
// Pipelined signed divider for (a << 16) / b, two quotient bits per stage.
`default_nettype none
module qfa_div import qfa_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [DATA_W-1:0] result,
    output logic              dz
);

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DIV_QW-1:0] dq;
        logic [DATA_W-1:0] den;
        logic              neg;
        logic              dz;
    } div_t;

    // One restoring step: shift in a dividend bit, subtract if it fits
    function automatic div_t div_iter(input div_t s);
        div_t        t;
        logic [DATA_W:0] r;
        t    = s;
        r    = {s.rem, s.dq[DIV_QW-1]};
        t.dq = {s.dq[DIV_QW-2:0], 1'b0};
        if (r >= {1'b0, s.den})
        begin
            r       = r - {1'b0, s.den};
            t.dq[0] = 1'b1;
        end
        t.rem = r[DATA_W-1:0];
        return t;
    endfunction

    div_t              div_reg  [DIV_STAGES+1];
    div_t              div_next [DIV_STAGES+1];
    logic [DATA_W-1:0] res_reg;
    logic [DATA_W-1:0] res_next;
    logic              dz_reg;
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;

    // Take magnitudes and the quotient sign
    always_comb
    begin
        a_mag            = a[DATA_W-1] ? (~a + 1'b1) : a;
        b_mag            = b[DATA_W-1] ? (~b + 1'b1) : b;
        div_next[0].rem  = '0;
        div_next[0].dq   = {a_mag, {FRAC_W{1'b0}}};
        div_next[0].den  = b_mag;
        div_next[0].neg  = a[DATA_W-1] ^ b[DATA_W-1];
        div_next[0].dz   = (b == '0);
    end

    // Resolve DIV_BPS quotient bits in each stage
    for (genvar g = 1; g <= DIV_STAGES; g++)
    begin : g_step
        always_comb
        begin
            div_next[g] = div_reg[g-1];
            for (int i = 0; i < DIV_BPS; i++)
            begin
                div_next[g] = div_iter(div_next[g]);
            end
        end
    end

    // Apply sign, force zero on a zero divisor
    always_comb
    begin
        if (div_reg[DIV_STAGES].dz)
        begin
            res_next = '0;
        end
        else if (div_reg[DIV_STAGES].neg)
        begin
            res_next = ~div_reg[DIV_STAGES].dq[DATA_W-1:0] + 1'b1;
        end
        else
        begin
            res_next = div_reg[DIV_STAGES].dq[DATA_W-1:0];
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                div_reg[k] <= div_next[k];
            end
            res_reg <= res_next;
            dz_reg  <= div_reg[DIV_STAGES].dz;
        end
    end

    assign result = res_reg;
    assign dz     = dz_reg;

endmodule
`default_nettype wire

[hdl/qfa_poly.sv]
// Multiply and sine/cosine series pipeline: power chain, term scaling, sum.
`default_nettype none
module qfa_poly import qfa_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  logic [OP_W-1:0]   op,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [DATA_W-1:0] result
);

    typedef struct packed {
        logic [OP_W-1:0]                   op;
        logic [DATA_W-1:0]                 x;
        logic [DATA_W-1:0]                 m;
        logic [POLY_TERMS-1:0][DATA_W-1:0] slot;
    } chain_t;

    typedef struct packed {
        logic [OP_W-1:0]                   op;
        logic [DATA_W-1:0]                 base;
        logic [DATA_W-1:0]                 mulv;
        logic [POLY_TERMS-1:0][DATA_W-1:0] val;
        logic [POLY_TERMS-1:0]             neg;
    } term_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] mulv;
        logic [DATA_W-1:0] u;
        logic [DATA_W-1:0] v;
    } sum_t;

    chain_t            chain_reg  [POLY_CHAIN+1];
    chain_t            chain_next [POLY_CHAIN+1];
    term_t             abs_reg;
    term_t             abs_next;
    term_t             quo_reg;
    term_t             quo_next;
    term_t             sgn_reg;
    term_t             sgn_next;
    sum_t              sum_reg;
    sum_t              sum_next;
    logic [DATA_W-1:0] res_reg;
    logic [DATA_W-1:0] res_next;
    logic [DATA_W-1:0] pad_reg [POLY_PAD];
    logic [DATA_W:0]   magic;
    logic [64:0]       prod   [POLY_TERMS];
    logic [64:0]       scaled [POLY_TERMS];

    // Load operands; a multiply uses b as the first factor
    always_comb
    begin
        chain_next[0].op   = op;
        chain_next[0].x    = a;
        chain_next[0].m    = (op == OP_MUL) ? b : a;
        chain_next[0].slot = '0;
    end

    // Build successive powers; keep the ones the series needs
    for (genvar j = 1; j <= POLY_CHAIN; j++)
    begin : g_pow
        localparam bit EVEN_POW = (j % 2 == 1);
        localparam int SLOT     = EVEN_POW ? (j - 1) / 2 : (j - 2) / 2;
        always_comb
        begin
            chain_next[j]   = chain_reg[j-1];
            chain_next[j].m = qmul(chain_reg[j-1].m, chain_reg[j-1].x);
            if (EVEN_POW)
            begin
                if (chain_reg[j-1].op != OP_SIN)
                begin
                    chain_next[j].slot[SLOT] = chain_next[j].m;
                end
            end
            else if (chain_reg[j-1].op == OP_SIN)
            begin
                chain_next[j].slot[SLOT] = chain_next[j].m;
            end
        end
    end

    // Split each stored power into sign and magnitude
    always_comb
    begin
        abs_next.op   = chain_reg[POLY_CHAIN].op;
        abs_next.base = (chain_reg[POLY_CHAIN].op == OP_COS) ? Q_ONE
                                                             : chain_reg[POLY_CHAIN].x;
        abs_next.mulv = chain_reg[POLY_CHAIN].slot[0];
        for (int k = 0; k < POLY_TERMS; k++)
        begin
            abs_next.neg[k] = chain_reg[POLY_CHAIN].slot[k][DATA_W-1];
            abs_next.val[k] = abs_next.neg[k] ? (~chain_reg[POLY_CHAIN].slot[k] + 1'b1)
                                              : chain_reg[POLY_CHAIN].slot[k];
        end
    end

    // Divide magnitudes by the term denominators through reciprocals
    always_comb
    begin
        quo_next = abs_reg;
        magic    = '0;
        for (int k = 0; k < POLY_TERMS; k++)
        begin
            magic     = term_magic(abs_reg.op == OP_COS, 2'(k));
            prod[k]   = {33'd0, abs_reg.val[k]} * {32'd0, magic};
            scaled[k] = prod[k] >> term_shift(abs_reg.op == OP_COS, 2'(k));
            quo_next.val[k] = scaled[k][DATA_W-1:0];
        end
    end

    // Restore the sign and fold in the alternating series sign
    always_comb
    begin
        sgn_next = quo_reg;
        for (int k = 0; k < POLY_TERMS; k++)
        begin
            if (quo_reg.neg[k] ^ (k % 2 == 0))
            begin
                sgn_next.val[k] = ~quo_reg.val[k] + 1'b1;
            end
        end
    end

    // Sum the series in two halves
    always_comb
    begin
        sum_next.op   = sgn_reg.op;
        sum_next.mulv = sgn_reg.mulv;
        sum_next.u    = sgn_reg.base + sgn_reg.val[0] + sgn_reg.val[1];
        sum_next.v    = sgn_reg.val[2] + sgn_reg.val[3];
    end

    // Pick the series sum or the plain product
    always_comb
    begin
        if (sum_reg.op == OP_SIN || sum_reg.op == OP_COS)
        begin
            res_next = sum_reg.u + sum_reg.v;
        end
        else
        begin
            res_next = sum_reg.mulv;
        end
    end

    // Advance every stage and the alignment delay together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= POLY_CHAIN; k++)
            begin
                chain_reg[k] <= chain_next[k];
            end
            abs_reg    <= abs_next;
            quo_reg    <= quo_next;
            sgn_reg    <= sgn_next;
            sum_reg    <= sum_next;
            res_reg    <= res_next;
            pad_reg[0] <= res_reg;
            for (int k = 1; k < POLY_PAD; k++)
            begin
                pad_reg[k] <= pad_reg[k-1];
            end
        end
    end

    assign result = pad_reg[POLY_PAD-1];

endmodule
`default_nettype wire

[hdl/q16_16_fixed_point_alu_top.sv]
// Q16.16 fixed-point ALU: top level with lane alignment and output skid buffer.
//
// Fully pipelined: one transaction enters per clock while the skid buffer is
// empty. The depth PIPE_DEPTH is set by the divider, which resolves the
// 48-bit quotient two bits per stage over 24 stages, plus an operand
// register and a sign fix-up register; multiply, sine and cosine run in a
// 13-stage power-chain unit padded to the same depth, and the simple ops
// ride an aligned delay line. Results pass through an output register with a
// one-entry skid buffer, so a stalled consumer holds the pipe only once that
// buffer fills. Dividing by zero returns zero with divide_by_zero set.
`default_nettype none
module q16_16_fixed_point_alu_top import qfa_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    qfa_req_if.sink   req,
    qfa_rsp_if.source rsp
);

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] res;
        logic              lt;
        logic              eq;
    } lane_t;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              lt;
        logic              eq;
        logic              dz;
    } rsp_t;

    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;
    lane_t                 lane_reg [PIPE_DEPTH];
    lane_t                 lane_next;
    logic [DATA_W-1:0]     div_res;
    logic                  div_dz;
    logic [DATA_W-1:0]     poly_res;
    rsp_t                  fin;
    logic                  fin_v;
    rsp_t                  out_reg;
    rsp_t                  out_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    rsp_t                  skid_reg;
    rsp_t                  skid_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;

    assign en        = !skid_valid_reg;
    assign req.ready = en;

    qfa_div u_div (
        .clk    (clk),
        .en     (en),
        .a      (req.operand_a),
        .b      (req.operand_b),
        .result (div_res),
        .dz     (div_dz)
    );

    qfa_poly u_poly (
        .clk    (clk),
        .en     (en),
        .op     (req.req_type),
        .a      (req.operand_a),
        .b      (req.operand_b),
        .result (poly_res)
    );

    // Compute the simple operations at entry
    always_comb
    begin
        lane_next.op  = req.req_type;
        lane_next.res = '0;
        lane_next.lt  = 1'b0;
        lane_next.eq  = 1'b0;
        case (req.req_type)
            OP_ADD:   lane_next.res = req.operand_a + req.operand_b;
            OP_SUB:   lane_next.res = req.operand_a - req.operand_b;
            OP_CMP:
            begin
                lane_next.lt = (req.operand_a < req.operand_b);
                lane_next.eq = (req.operand_a == req.operand_b);
            end
            OP_FLOOR: lane_next.res = {{FRAC_W{req.operand_a[DATA_W-1]}},
                                       req.operand_a[DATA_W-1:FRAC_W]};
            OP_FRAC:  lane_next.res = req.operand_a & FRAC_MASK;
            default:  lane_next.res = '0;
        endcase
    end

    // Move valid bits along with the lane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg[0] <= lane_next;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                lane_reg[k] <= lane_reg[k-1];
            end
        end
    end

    // Merge unit results at the pipe end
    always_comb
    begin
        fin_v  = vld_reg[PIPE_DEPTH-1];
        fin.lt = lane_reg[PIPE_DEPTH-1].lt;
        fin.eq = lane_reg[PIPE_DEPTH-1].eq;
        fin.dz = 1'b0;
        case (lane_reg[PIPE_DEPTH-1].op)
            OP_DIV:
            begin
                fin.res = div_res;
                fin.dz  = div_dz;
            end
            OP_MUL, OP_SIN, OP_COS: fin.res = poly_res;
            default:                fin.res = lane_reg[PIPE_DEPTH-1].res;
        endcase
    end

    // Hand the transaction to the output register or park it in the skid
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || rsp.ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = fin;
                out_valid_next = en && fin_v;
            end
        end
        else if (en && fin_v)
        begin
            skid_next       = fin;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_value   = out_reg.res;
    assign rsp.a_less_b       = out_reg.lt;
    assign rsp.a_equal_b      = out_reg.eq;
    assign rsp.divide_by_zero = out_reg.dz;

endmodule
`default_nettype wire

[hdl/qfa_check.sv]
// Port-level checks on the ALU response channel, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module qfa_check (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_value,
    input logic        lt,
    input logic        eq,
    input logic        dz
);

    // Hold a stalled response
    `QFA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(lt) && $stable(eq) && $stable(dz))
    // Compare flags are exclusive
    `QFA_ASSERT_NOW(a_cmp_excl, clk, rst_n, rsp_valid, !(lt && eq))
    // Divide by zero returns zero and no compare flags
    `QFA_ASSERT_NOW(a_dz_zero, clk, rst_n, rsp_valid && dz, rsp_value == 32'd0 && !lt && !eq)
    // Compare returns zero
    `QFA_ASSERT_NOW(a_cmp_zero, clk, rst_n, rsp_valid && (lt || eq), rsp_value == 32'd0)

endmodule

bind q16_16_fixed_point_alu_top qfa_check u_qfa_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_value (rsp.result_value),
    .lt        (rsp.a_less_b),
    .eq        (rsp.a_equal_b),
    .dz        (rsp.divide_by_zero)
);
`default_nettype wire

[sim/tb.sv]
// Testbench for the Q16.16 fixed-point ALU: random and directed operations checked against a local model.
`timescale 1ns / 1ps
module tb;
    import qfa_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_op_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              lt;
        logic              eq;
        logic              dz;
    } alu_res_t;

    logic clk;
    logic rst_n;

    qfa_req_if req ();
    qfa_rsp_if rsp ();

    q16_16_fixed_point_alu_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int       mismatch_count;
    bit       stim_done;
    bit       quiet_stretch;
    bit       hold_sender;

    // Rounded Q16.16 product, floor shift, low 32 bits
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
        logic signed [63:0] p;
        logic signed [31:0] w;
        p = x * y + 64'sd32768;
        p = p >>> 16;
        w = p[31:0];
        return w;
    endfunction

    // Truncating Q16.16 divide by a 64-bit divisor, low 32 bits
    function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
                                                 input logic signed [63:0] d);
        logic signed [63:0] q;
        logic signed [31:0] w;
        q = (n * 64'sd65536) / d;
        w = q[31:0];
        return w;
    endfunction

    function automatic logic signed [63:0] wrap(input logic signed [63:0] v);
        logic signed [31:0] w;
        w = v[31:0];
        return w;
    endfunction

    function automatic alu_res_t alu_predict(input alu_op_t op);
        alu_res_t r;
        logic signed [63:0] a, b, v, p2, p3, p4, p5, p6, p7, p8;
        a = $signed(op.a);
        b = $signed(op.b);
        r = '0;
        v = 0;
        case (op.opcode)
            OP_ADD: v = wrap(a + b);
            OP_SUB: v = wrap(a - b);
            OP_MUL: v = fx_mul(a, b);
            OP_DIV:
            begin
                if (b == 0) r.dz = 1'b1;
                else v = fx_div(a, b);
            end
            OP_CMP:
            begin
                r.lt = (a < b);
                r.eq = (a == b);
            end
            OP_FLOOR: v = a >>> 16;
            OP_FRAC: v = a & 64'h0000_FFFF;
            OP_SIN:
            begin
                p3 = fx_mul(fx_mul(a, a), a);
                p5 = fx_mul(fx_mul(p3, a), a);
                p7 = fx_mul(fx_mul(p5, a), a);
                v = wrap(a - fx_div(p3, 64'sd6 * 65536));
                v = wrap(v + fx_div(p5, 64'sd120 * 65536));
                v = wrap(v - fx_div(p7, 64'sd5040 * 65536));
            end
            OP_COS:
            begin
                p2 = fx_mul(a, a);
                p4 = fx_mul(fx_mul(p2, a), a);
                p6 = fx_mul(fx_mul(p4, a), a);
                p8 = fx_mul(fx_mul(p6, a), a);
                v = wrap(64'sd65536 - fx_div(p2, 64'sd2 * 65536));
                v = wrap(v + fx_div(p4, 64'sd24 * 65536));
                v = wrap(v - fx_div(p6, 64'sd720 * 65536));
                v = wrap(v + fx_div(p8, 64'sd40320 * 65536));
            end
            default: v = 0;
        endcase
        r.value = v[31:0];
        return r;
    endfunction

    // Operand biased toward edges, small angles and plain random words
    function automatic logic [31:0] pick_operand(input logic [3:0] opcode);
        int sel;
        sel = $urandom_range(0, 9);
        if ((opcode == OP_SIN || opcode == OP_COS) && sel < 6)
            return $urandom_range(0, 1) ? $urandom_range(0, 32'h0006_0000)
                                        : -$urandom_range(0, 32'h0006_0000);
        case (sel)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return $urandom_range(0, 1) ? $urandom_range(0, 32'h000F_FFFF)
                                           : -$urandom_range(0, 32'h000F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(input logic [3:0] opcode, input logic [31:0] a,
                            input logic [31:0] b);
        alu_op_t op;
        op.opcode = opcode;
        op.a = a;
        op.b = b;
        pending_ops.push_back(op);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stimulus: reset, directed operations, then random transactions
    initial
    begin
        logic [3:0] opc;
        logic [31:0] a, b;
        rst_n = 1'b0;
        stim_done = 1'b0;
        hold_sender = 1'b0;
        quiet_stretch = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes, every opcode, divide by zero, unknown opcodes
        queue_op(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        queue_op(OP_SUB, 32'h8000_0000, 32'h0000_0001);
        queue_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        queue_op(OP_MUL, 32'hFFFF_8000, 32'h0000_0001);
        queue_op(OP_DIV, 32'h0001_0000, 32'h0000_0000);
        queue_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(OP_DIV, 32'hFFFF_FFFF, 32'h0003_0000);
        queue_op(OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_op(OP_CMP, 32'h1234_5678, 32'h1234_5678);
        queue_op(OP_CMP, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_op(OP_FLOOR, 32'hFFFF_0001, 32'hFFFF_FFFF);
        queue_op(OP_FLOOR, 32'h7FFF_FFFF, 32'h0);
        queue_op(OP_FRAC, 32'hFFFF_FFFF, 32'h0);
        queue_op(OP_SIN, 32'h0001_921F, 32'h0);
        queue_op(OP_SIN, 32'h8000_0000, 32'h0);
        queue_op(OP_SIN, 32'h7FFF_FFFF, 32'h0);
        queue_op(OP_COS, 32'h0000_0000, 32'h0);
        queue_op(OP_COS, 32'hFFFC_0000, 32'h0);
        queue_op(OP_COS, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(4'd9, 32'h1, 32'h2);
        queue_op(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Drain once, then hold the sender until every result is back
        wait (pending_ops.size() == 0);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0);
        @(posedge clk);
        hold_sender <= 1'b0;

        for (int i = 0; i < 1600; i++)
        begin
            if (i == 600) quiet_stretch = 1'b1;
            if (i == 900) quiet_stretch = 1'b0;
            opc = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
            a = pick_operand(opc);
            b = pick_operand(opc);
            queue_op(opc, a, b);
            if (pending_ops.size() > 8) wait (pending_ops.size() <= 8);
        end
        wait (pending_ops.size() == 0);
        stim_done = 1'b1;
    end

    // Driver: present the next operation, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        alu_op_t op;
        if (!rst_n)
        begin
            req.valid     <= 1'b0;
            req.req_type  <= '0;
            req.operand_a <= '0;
            req.operand_b <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_results.push_back(alu_predict({req.req_type, req.operand_a,
                                                        req.operand_b}));
                void'(pending_ops.pop_front());
            end
            if (!(req.valid && !req.ready))
            begin
                if (pending_ops.size() > 0 && !hold_sender
                    && (quiet_stretch || $urandom_range(0, 99) >= 25))
                begin
                    op = pending_ops[0];
                    req.valid     <= 1'b1;
                    req.req_type  <= op.opcode;
                    req.operand_a <= op.a;
                    req.operand_b <= op.b;
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        alu_res_t exp_res;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            mismatch_count <= 0;
        end
        else
        begin
            rsp.ready <= quiet_stretch || ($urandom_range(0, 99) >= 25);
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result %h", rsp.result_value);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (exp_res.value !== rsp.result_value || exp_res.lt !== rsp.a_less_b
                        || exp_res.eq !== rsp.a_equal_b || exp_res.dz !== rsp.divide_by_zero)
                    begin
                        if (mismatch_count < 10)
                            $display("mismatch: exp %h lt%b eq%b dz%b got %h lt%b eq%b dz%b",
                                     exp_res.value, exp_res.lt, exp_res.eq, exp_res.dz,
                                     rsp.result_value, rsp.a_less_b, rsp.a_equal_b,
                                     rsp.divide_by_zero);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end

    // Finish once everything has drained and the pipe is quiet
    initial
    begin
        wait (stim_done);
        wait (expected_results.size() == 0);
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Timeout
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
